// File: rtl/frsc_pkg.sv
// ----------------------------------------------------------------------------
// frsc_pkg
// Shared types, register indexes, codes and constants for the follow-robot
// steering controller.
// ----------------------------------------------------------------------------
package frsc_pkg;

    // field widths
    localparam int RANGE_BITS        = 12;
    localparam int CFG_BITS          = 16;
    localparam int CFG_IDX_BITS      = 3;
    localparam int CMD_BITS          = 3;
    localparam int TAG_RANGE_BITS_DEF = 16;

    // arithmetic unit
    localparam int DIGIT_BITS = 16;
    localparam int TAN_BITS   = 19;
    localparam int ASQ_BITS   = 32;
    localparam int R_SHIFT    = 16;

    // tan^2 of 40 and 70 degrees, Q16
    localparam logic [TAN_BITS-1:0] TAN2_40 = 19'd46143;
    localparam logic [TAN_BITS-1:0] TAN2_70 = 19'd494707;

    localparam logic [1:0] HOLD_RELOAD = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ANCHOR_SPACING   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FOLLOW_DISTANCE  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOST_DISTANCE    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALARM_DISTANCE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLEAR_AHEAD      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BACKOFF_DISTANCE = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AVOID_DISTANCE   = 3'd6;

    // configuration reset values
    localparam logic [CFG_BITS-1:0]   RST_ANCHOR_SPACING   = 16'd20;
    localparam logic [CFG_BITS-1:0]   RST_FOLLOW_DISTANCE  = 16'd120;
    localparam logic [CFG_BITS-1:0]   RST_LOST_DISTANCE    = 16'd300;
    localparam logic [CFG_BITS-1:0]   RST_ALARM_DISTANCE   = 16'd400;
    localparam logic [RANGE_BITS-1:0] RST_CLEAR_AHEAD      = 12'd80;
    localparam logic [RANGE_BITS-1:0] RST_BACKOFF_DISTANCE = 12'd30;
    localparam logic [RANGE_BITS-1:0] RST_AVOID_DISTANCE   = 12'd50;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_NONE    = 3'd0,
        CMD_FORWARD = 3'd1,
        CMD_LEFT    = 3'd2,
        CMD_RIGHT   = 3'd3,
        CMD_BACK    = 3'd4,
        CMD_STOP    = 3'd5
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_A,
        S_SQ_T0,
        S_SQ_T1,
        S_SQ_T2,
        S_SUM,
        S_DIFF_B,
        S_SQ_D,
        S_MUL_BK40,
        S_MUL_L40,
        S_MUL_BK70,
        S_MUL_L70,
        S_DECIDE
    } t_state;

endpackage

// File: rtl/frsc_item_if.sv
// ----------------------------------------------------------------------------
// frsc_item_if
// Input channel: three obstacle ranges and three tag-to-anchor ranges.
// ----------------------------------------------------------------------------
interface frsc_item_if #(
    parameter int TAG_BITS = frsc_pkg::TAG_RANGE_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic [frsc_pkg::RANGE_BITS-1:0] left_range;
    logic [frsc_pkg::RANGE_BITS-1:0] middle_range;
    logic [frsc_pkg::RANGE_BITS-1:0] right_range;
    logic [TAG_BITS-1:0]             tag_to_anchor0;
    logic [TAG_BITS-1:0]             tag_to_anchor1;
    logic [TAG_BITS-1:0]             tag_to_anchor2;

    modport source (
        output valid, left_range, middle_range, right_range,
               tag_to_anchor0, tag_to_anchor1, tag_to_anchor2,
        input  ready
    );

    modport sink (
        input  valid, left_range, middle_range, right_range,
               tag_to_anchor0, tag_to_anchor1, tag_to_anchor2,
        output ready
    );
endinterface

// File: rtl/frsc_result_if.sv
// ----------------------------------------------------------------------------
// frsc_result_if
// Output channel: motor command with beep and call flags.
// ----------------------------------------------------------------------------
interface frsc_result_if;
    logic                          valid;
    logic                          ready;
    logic [frsc_pkg::CMD_BITS-1:0] motor_command;
    logic                          beep_request;
    logic                          call_request;

    modport source (
        output valid, motor_command, beep_request, call_request,
        input  ready
    );

    modport sink (
        input  valid, motor_command, beep_request, call_request,
        output ready
    );
endinterface

// File: rtl/follow_robot_steering_control_top.sv
// ----------------------------------------------------------------------------
// follow_robot_steering_control_top
// Steering controller for a tag-following robot: tag side and bearing tests
// on one shared multiplier, then the prioritised steering and range rules.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_item    in   valid / ready    three obstacle ranges, three tag ranges
//  o_result  out  valid / ready    motor_command, beep_request, call_request
//  i_cfg_*   in   write enable     register index, 16-bit data
//
//  The 16-bit-digit multiplier forms every square and the two bearing products
//  one digit per cycle; a new item is accepted only once the previous one has
//  been through the decision step and the controller is idle again.
//  Reset (synchronous, active low) clears the turn modes, hold counters and
//  output valid, and loads the configuration reset values.
//  A held result does not block the next item; the decision step waits only
//  if the previous result has not yet been transferred.
// ----------------------------------------------------------------------------
module follow_robot_steering_control_top #(
    parameter int TAG_RANGE_BITS = frsc_pkg::TAG_RANGE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [frsc_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [frsc_pkg::CFG_BITS-1:0]     i_cfg_data,
    frsc_item_if.sink                         i_item,
    frsc_result_if.source                     o_result
);

    localparam int TW    = TAG_RANGE_BITS;
    localparam int SQW   = 2 * TW;
    localparam int DW    = frsc_pkg::DIGIT_BITS;
    localparam int KW    = frsc_pkg::TAN_BITS;
    localparam int RW    = frsc_pkg::RANGE_BITS;
    localparam int CFW   = frsc_pkg::CFG_BITS;
    localparam int AQW   = frsc_pkg::ASQ_BITS;
    localparam int MB    = (SQW + 2 > AQW + 2) ? SQW + 2 : AQW + 2;
    localparam int BW    = MB + 1;
    localparam int XW    = MB;
    localparam int ND_A  = (CFW + DW - 1) / DW;
    localparam int ND_T  = (TW + DW - 1) / DW;
    localparam int ND_D3 = (SQW + 2 + DW - 1) / DW;
    localparam int ND_K  = (KW + DW - 1) / DW;
    localparam int ND_BK = (MB + KW + DW - 1) / DW;
    localparam int YW    = ND_BK * DW;
    localparam int PW    = 2 * MB + KW;
    localparam int CNTW  = $clog2(ND_BK + 1);
    localparam int CMPW  = (TW > CFW) ? TW : CFW;

    // configuration
    logic [CFW-1:0] r_anchor_spacing, r_follow_distance, r_lost_distance;
    logic [CFW-1:0] r_alarm_distance;
    logic [RW-1:0]  r_clear_ahead, r_backoff_distance, r_avoid_distance;

    // control state
    frsc_pkg::t_state r_state, n_state;
    logic             r_turn_left, n_turn_left, r_turn_right, n_turn_right;
    logic [1:0]       r_left_hold, n_left_hold, r_right_hold, n_right_hold;
    logic             r_out_valid, n_out_valid;

    // datapath
    logic [RW-1:0]    r_dl, r_dm, r_dr;
    logic [TW-1:0]    r_t0, r_t1, r_t2;
    logic [AQW-1:0]   r_asq, n_asq;
    logic [SQW-1:0]   r_t0sq, n_t0sq, r_t1sq, n_t1sq, r_t2sq, n_t2sq;
    logic signed [SQW:0]  r_d, n_d;
    logic signed [BW-1:0] r_b, n_b;
    logic [PW-1:0]    r_r, n_r;
    logic             r_le40, n_le40, r_lt40, n_lt40, r_le70, n_le70, r_lt70, n_lt70;
    logic [XW-1:0]    r_mx, n_mx;
    logic [YW-1:0]    r_my, n_my;
    logic [PW-1:0]    r_acc, n_acc;
    logic [CNTW-1:0]  r_cnt, n_cnt;
    frsc_pkg::t_cmd   r_cmd, n_cmd;
    logic             r_beep, n_beep, r_call, n_call;

    // shared multiply-accumulate step, multiplier digits taken MSB first
    logic [DW-1:0]    w_digit;
    logic [XW+DW-1:0] w_prod;
    logic [PW-1:0]    w_acc_next;
    logic             w_last;

    assign w_digit    = r_my[YW-1 -: DW];
    assign w_prod     = r_mx * w_digit;
    assign w_acc_next = (r_acc << DW) + PW'(w_prod);
    assign w_last     = (r_cnt == CNTW'(1));

    logic w_in_fire, w_out_free;
    assign i_item.ready = (r_state == frsc_pkg::S_IDLE);
    assign w_in_fire    = i_item.valid && i_item.ready;
    assign w_out_free   = !r_out_valid || o_result.ready;

    assign o_result.valid         = r_out_valid;
    assign o_result.motor_command = r_cmd;
    assign o_result.beep_request  = r_beep;
    assign o_result.call_request  = r_call;

    // |d| and 3|d| for the d^2 product
    logic [SQW-1:0]   w_dmag;
    logic [SQW+1:0]   w_dmag3;
    assign w_dmag  = r_d[SQW] ? SQW'(-r_d) : SQW'(r_d);
    assign w_dmag3 = {w_dmag, 1'b0} + (SQW + 2)'(w_dmag);

    // ---------------- decision ----------------
    logic [CMPW-1:0] w_t2, w_fol, w_lost, w_alarm;
    logic            w_in_band, w_degen, w_b_pos, w_d_pos;
    logic            w_ge40, w_gt40, w_ge70, w_gt70;
    logic            w_any_back, w_side_avoid;

    assign w_t2    = CMPW'(r_t2);
    assign w_fol   = CMPW'(r_follow_distance);
    assign w_lost  = CMPW'(r_lost_distance);
    assign w_alarm = CMPW'(r_alarm_distance);

    assign w_in_band = (w_t2 > w_fol) && (w_t2 < w_lost);
    assign w_degen   = (r_b == '0) && (r_d == '0);
    assign w_b_pos   = !r_b[MB] && (r_b != '0);
    assign w_d_pos   = !r_d[SQW] && (r_d != '0);
    // bearing at or beyond / strictly beyond the threshold; b <= 0 is at or past 90
    assign w_ge40 = !w_degen && (!w_b_pos || r_le40);
    assign w_gt40 = !w_degen && (!w_b_pos || r_lt40);
    assign w_ge70 = !w_degen && (!w_b_pos || r_le70);
    assign w_gt70 = !w_degen && (!w_b_pos || r_lt70);

    assign w_any_back   = (r_dl < r_backoff_distance) || (r_dm < r_backoff_distance)
                       || (r_dr < r_backoff_distance);
    assign w_side_avoid = (r_dl < r_avoid_distance) || (r_dr < r_avoid_distance);

    frsc_pkg::t_cmd w_cmd;
    logic           w_tl, w_tr, w_beep, w_call;
    logic [1:0]     w_lh, w_rh;

    always_comb begin
        w_cmd  = frsc_pkg::CMD_NONE;
        w_tl   = r_turn_left;
        w_tr   = r_turn_right;
        w_lh   = r_left_hold;
        w_rh   = r_right_hold;
        w_beep = 1'b0;
        w_call = 1'b0;
        if (w_in_band) begin
            if (r_right_hold != 2'd0) w_rh = r_right_hold - 2'd1;
            if (r_left_hold != 2'd0)  w_lh = r_left_hold - 2'd1;
            if (r_turn_left) begin
                if (r_dm < r_clear_ahead) begin
                    w_cmd = frsc_pkg::CMD_LEFT;
                end else begin
                    w_tl = 1'b0;
                    w_rh = frsc_pkg::HOLD_RELOAD;
                end
            end else if (r_turn_right) begin
                if (r_dm < r_clear_ahead) begin
                    w_cmd = frsc_pkg::CMD_RIGHT;
                end else begin
                    w_tr = 1'b0;
                    w_lh = frsc_pkg::HOLD_RELOAD;
                end
            end else if (w_any_back) begin
                w_cmd = frsc_pkg::CMD_BACK;
            end else if (w_side_avoid) begin
                if (r_dl < r_avoid_distance) begin
                    w_cmd = frsc_pkg::CMD_RIGHT;
                    w_lh  = frsc_pkg::HOLD_RELOAD;
                end else begin
                    w_cmd = frsc_pkg::CMD_LEFT;
                    w_rh  = frsc_pkg::HOLD_RELOAD;
                end
            end else if (!w_d_pos && ((w_ge40 && (r_dl >= r_clear_ahead)) || w_ge70)
                         && (w_lh == 2'd0)) begin
                w_cmd = frsc_pkg::CMD_LEFT;
            end else if (w_d_pos && ((w_gt40 && (r_dr > r_clear_ahead)) || w_gt70)
                         && (w_rh == 2'd0)) begin
                w_cmd = frsc_pkg::CMD_RIGHT;
            end else if (r_dm < r_avoid_distance) begin
                if ((r_dr > r_avoid_distance) || (r_dl > r_avoid_distance)) begin
                    if (r_dr > r_dl) w_tr = 1'b1;
                    else w_tl = 1'b1;
                end
            end else if ((w_rh == 2'd0) && (w_lh == 2'd0)) begin
                w_cmd = frsc_pkg::CMD_FORWARD;
            end else begin
                w_cmd = frsc_pkg::CMD_STOP;
            end
        end
        if (w_t2 < w_fol) w_cmd = frsc_pkg::CMD_STOP;
        if ((w_t2 >= w_lost) && (w_t2 < w_alarm)) w_beep = 1'b1;
        if (w_t2 >= w_alarm) begin
            w_cmd  = frsc_pkg::CMD_STOP;
            w_call = 1'b1;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state      = r_state;
        n_turn_left  = r_turn_left;
        n_turn_right = r_turn_right;
        n_left_hold  = r_left_hold;
        n_right_hold = r_right_hold;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_asq  = r_asq;
        n_t0sq = r_t0sq;
        n_t1sq = r_t1sq;
        n_t2sq = r_t2sq;
        n_d    = r_d;
        n_b    = r_b;
        n_r    = r_r;
        n_le40 = r_le40;
        n_lt40 = r_lt40;
        n_le70 = r_le70;
        n_lt70 = r_lt70;
        n_mx   = r_mx;
        n_my   = r_my;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_cmd  = r_cmd;
        n_beep = r_beep;
        n_call = r_call;

        case (r_state)
            frsc_pkg::S_IDLE, frsc_pkg::S_SUM, frsc_pkg::S_DIFF_B,
            frsc_pkg::S_DECIDE: begin
            end
            default: begin
                n_acc = w_acc_next;
                n_my  = r_my << DW;
                n_cnt = r_cnt - CNTW'(1);
            end
        endcase

        case (r_state)
            frsc_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_mx    = XW'(r_anchor_spacing);
                    n_my    = YW'(r_anchor_spacing) << (YW - ND_A * DW);
                    n_cnt   = CNTW'(ND_A);
                    n_acc   = '0;
                    n_state = frsc_pkg::S_SQ_A;
                end
            end
            frsc_pkg::S_SQ_A: begin
                if (w_last) begin
                    n_asq   = w_acc_next[AQW-1:0];
                    n_mx    = XW'(r_t0);
                    n_my    = YW'(r_t0) << (YW - ND_T * DW);
                    n_cnt   = CNTW'(ND_T);
                    n_acc   = '0;
                    n_state = frsc_pkg::S_SQ_T0;
                end
            end
            frsc_pkg::S_SQ_T0: begin
                if (w_last) begin
                    n_t0sq  = w_acc_next[SQW-1:0];
                    n_mx    = XW'(r_t1);
                    n_my    = YW'(r_t1) << (YW - ND_T * DW);
                    n_cnt   = CNTW'(ND_T);
                    n_acc   = '0;
                    n_state = frsc_pkg::S_SQ_T1;
                end
            end
            frsc_pkg::S_SQ_T1: begin
                if (w_last) begin
                    n_t1sq  = w_acc_next[SQW-1:0];
                    n_mx    = XW'(r_t2);
                    n_my    = YW'(r_t2) << (YW - ND_T * DW);
                    n_cnt   = CNTW'(ND_T);
                    n_acc   = '0;
                    n_state = frsc_pkg::S_SQ_T2;
                end
            end
            frsc_pkg::S_SQ_T2: begin
                if (w_last) begin
                    n_t2sq  = w_acc_next[SQW-1:0];
                    n_state = frsc_pkg::S_SUM;
                end
            end
            frsc_pkg::S_SUM: begin
                n_d     = (SQW + 1)'(r_t0sq) - (SQW + 1)'(r_t1sq);
                n_b     = BW'({r_asq, 1'b0}) + BW'({r_t2sq, 1'b0});
                n_state = frsc_pkg::S_DIFF_B;
            end
            frsc_pkg::S_DIFF_B: begin
                n_b     = r_b - BW'(r_t0sq) - BW'(r_t1sq);
                n_mx    = XW'(w_dmag);
                n_my    = YW'(w_dmag3) << (YW - ND_D3 * DW);
                n_cnt   = CNTW'(ND_D3);
                n_acc   = '0;
                n_state = frsc_pkg::S_SQ_D;
            end
            frsc_pkg::S_SQ_D: begin
                if (w_last) begin
                    n_r     = w_acc_next << frsc_pkg::R_SHIFT;
                    // only used when b > 0, so the low bits are its magnitude
                    n_mx    = r_b[MB-1:0];
                    n_my    = YW'(frsc_pkg::TAN2_40) << (YW - ND_K * DW);
                    n_cnt   = CNTW'(ND_K);
                    n_acc   = '0;
                    n_state = frsc_pkg::S_MUL_BK40;
                end
            end
            frsc_pkg::S_MUL_BK40: begin
                if (w_last) begin
                    n_my    = YW'(w_acc_next[MB+KW-1:0]) << (YW - ND_BK * DW);
                    n_cnt   = CNTW'(ND_BK);
                    n_acc   = '0;
                    n_state = frsc_pkg::S_MUL_L40;
                end
            end
            frsc_pkg::S_MUL_L40: begin
                if (w_last) begin
                    n_le40  = (w_acc_next <= r_r);
                    n_lt40  = (w_acc_next < r_r);
                    n_my    = YW'(frsc_pkg::TAN2_70) << (YW - ND_K * DW);
                    n_cnt   = CNTW'(ND_K);
                    n_acc   = '0;
                    n_state = frsc_pkg::S_MUL_BK70;
                end
            end
            frsc_pkg::S_MUL_BK70: begin
                if (w_last) begin
                    n_my    = YW'(w_acc_next[MB+KW-1:0]) << (YW - ND_BK * DW);
                    n_cnt   = CNTW'(ND_BK);
                    n_acc   = '0;
                    n_state = frsc_pkg::S_MUL_L70;
                end
            end
            frsc_pkg::S_MUL_L70: begin
                if (w_last) begin
                    n_le70  = (w_acc_next <= r_r);
                    n_lt70  = (w_acc_next < r_r);
                    n_state = frsc_pkg::S_DECIDE;
                end
            end
            frsc_pkg::S_DECIDE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_cmd        = w_cmd;
                    n_beep       = w_beep;
                    n_call       = w_call;
                    n_turn_left  = w_tl;
                    n_turn_right = w_tr;
                    n_left_hold  = w_lh;
                    n_right_hold = w_rh;
                    n_state      = frsc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = frsc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= frsc_pkg::S_IDLE;
            r_turn_left  <= 1'b0;
            r_turn_right <= 1'b0;
            r_left_hold  <= 2'd0;
            r_right_hold <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_turn_left  <= n_turn_left;
            r_turn_right <= n_turn_right;
            r_left_hold  <= n_left_hold;
            r_right_hold <= n_right_hold;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anchor_spacing   <= frsc_pkg::RST_ANCHOR_SPACING;
            r_follow_distance  <= frsc_pkg::RST_FOLLOW_DISTANCE;
            r_lost_distance    <= frsc_pkg::RST_LOST_DISTANCE;
            r_alarm_distance   <= frsc_pkg::RST_ALARM_DISTANCE;
            r_clear_ahead      <= frsc_pkg::RST_CLEAR_AHEAD;
            r_backoff_distance <= frsc_pkg::RST_BACKOFF_DISTANCE;
            r_avoid_distance   <= frsc_pkg::RST_AVOID_DISTANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                frsc_pkg::CFG_ANCHOR_SPACING:   r_anchor_spacing   <= i_cfg_data;
                frsc_pkg::CFG_FOLLOW_DISTANCE:  r_follow_distance  <= i_cfg_data;
                frsc_pkg::CFG_LOST_DISTANCE:    r_lost_distance    <= i_cfg_data;
                frsc_pkg::CFG_ALARM_DISTANCE:   r_alarm_distance   <= i_cfg_data;
                frsc_pkg::CFG_CLEAR_AHEAD:      r_clear_ahead      <= i_cfg_data[RW-1:0];
                frsc_pkg::CFG_BACKOFF_DISTANCE: r_backoff_distance <= i_cfg_data[RW-1:0];
                frsc_pkg::CFG_AVOID_DISTANCE:   r_avoid_distance   <= i_cfg_data[RW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_dl <= i_item.left_range;
            r_dm <= i_item.middle_range;
            r_dr <= i_item.right_range;
            r_t0 <= TW'(i_item.tag_to_anchor0);
            r_t1 <= TW'(i_item.tag_to_anchor1);
            r_t2 <= TW'(i_item.tag_to_anchor2);
        end
        r_asq  <= n_asq;
        r_t0sq <= n_t0sq;
        r_t1sq <= n_t1sq;
        r_t2sq <= n_t2sq;
        r_d    <= n_d;
        r_b    <= n_b;
        r_r    <= n_r;
        r_le40 <= n_le40;
        r_lt40 <= n_lt40;
        r_le70 <= n_le70;
        r_lt70 <= n_lt70;
        r_mx   <= n_mx;
        r_my   <= n_my;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_cmd  <= n_cmd;
        r_beep <= n_beep;
        r_call <= n_call;
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input taken while an item is in progress");

    a_modes_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_turn_left && r_turn_right))
        else $error("both turn modes set");

    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left_hold != 2'd3) && (r_right_hold != 2'd3))
        else $error("obstacle hold counter out of range");

    a_result_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(r_state == frsc_pkg::S_DECIDE))
        else $error("result loaded outside the decision step");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == frsc_pkg::S_IDLE || r_state == frsc_pkg::S_SUM
          || r_state == frsc_pkg::S_DIFF_B || r_state == frsc_pkg::S_DECIDE)
        |-> (r_cnt != '0))
        else $error("multiplier step with no digits left");
`endif

endmodule
